>>> sv/mic_pkg.sv
// mic_pkg: shared widths, types and register codes for the magnetometer
// calibration block. No dependencies.
package mic_pkg;

   localparam int RAW_W   = 16;  // raw sample field
   localparam int BIAS_W  = 48;  // packed bias register
   localparam int ROW_W   = 54;  // packed matrix row register
   localparam int CSR_W   = 54;  // config data port, widest register
   localparam int COEF_W  = 18;  // Q3.15 coefficient
   localparam int D_W     = 17;  // raw minus bias
   localparam int PROD_W  = 35;  // coefficient times difference
   localparam int V_W     = 37;  // calibrated component, signed
   localparam int MAG_W   = 36;  // calibrated magnitude per axis
   localparam int HALF_W  = 18;  // half of a magnitude for split squaring
   localparam int SQ_W    = 72;  // sum of squares
   localparam int ROOT_W  = 36;  // integer square root
   localparam int FRAC_W  = 14;  // Q1.14 output fraction
   localparam int NUM_W   = 51;  // division dividend
   localparam int QUO_W   = 15;  // quotient, at most 16384
   localparam int OUT_W   = 16;  // unit vector component

   localparam int QUEUE_DEPTH = 4;

   // config register indexes
   typedef enum logic [1:0] {
      REG_BIAS,
      REG_ROW_ZERO,
      REG_ROW_ONE,
      REG_ROW_TWO
   } reg_index_type;

   localparam logic [ROW_W-1:0] ROW_ZERO_RESET = ROW_W'(1) << 15;
   localparam logic [ROW_W-1:0] ROW_ONE_RESET  = ROW_W'(1) << 33;
   localparam logic [ROW_W-1:0] ROW_TWO_RESET  = ROW_W'(1) << 51;

   typedef logic [2:0][D_W-1:0]               diff_vec_type;
   typedef logic [2:0][2:0][COEF_W-1:0]       matrix_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

>>> sv/magnetometer_iron_calibration.sv
// magnetometer_iron_calibration: top level, config registers, front stage,
// queue and calibration pipeline. Depends on mic_pkg, mic_front, mic_fifo, mic_back.
//
//   port group | direction | word
//   req_*      | in        | raw_x, raw_y, raw_z
//   rsp_*      | out       | unit_x, unit_y, unit_z, zero_magnitude
//   csr_*      | in        | write enable, index, data
//
// One word per cycle sustained while rsp_ready stays high. A word passes the front
// register, queue, four multiply and square stages, root entry, 36 root stages,
// divider entry, 15 divider stages and the result register.
// Synchronous reset clears valid, pointers and bias and loads an identity matrix.
// A stalled result freezes the back pipeline; the queue keeps the front taking
// words until it is full.
module magnetometer_iron_calibration #(
   parameter int QUEUE_DEPTH = mic_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [mic_pkg::RAW_W-1:0] req_raw_x,
   input  logic signed [mic_pkg::RAW_W-1:0] req_raw_y,
   input  logic signed [mic_pkg::RAW_W-1:0] req_raw_z,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [mic_pkg::OUT_W-1:0] rsp_unit_x,
   output logic signed [mic_pkg::OUT_W-1:0] rsp_unit_y,
   output logic signed [mic_pkg::OUT_W-1:0] rsp_unit_z,
   output logic                             rsp_zero_magnitude,
   input  logic                             csr_write,
   input  logic [1:0]                       csr_index,
   input  logic [mic_pkg::CSR_W-1:0]        csr_data
);

   logic [mic_pkg::BIAS_W-1:0] bias_ff;
   logic [mic_pkg::ROW_W-1:0]  row_zero_ff, row_one_ff, row_two_ff;
   mic_pkg::matrix_type        matrix;
   mic_pkg::queue_status_type  queue_status;
   mic_pkg::diff_vec_type      push_data, pop_data;
   logic                       push, pop;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff     <= '0;
         row_zero_ff <= mic_pkg::ROW_ZERO_RESET;
         row_one_ff  <= mic_pkg::ROW_ONE_RESET;
         row_two_ff  <= mic_pkg::ROW_TWO_RESET;
      end else if (csr_write) begin
         case (mic_pkg::reg_index_type'(csr_index))
            mic_pkg::REG_BIAS:     bias_ff     <= csr_data[mic_pkg::BIAS_W-1:0];
            mic_pkg::REG_ROW_ZERO: row_zero_ff <= csr_data[mic_pkg::ROW_W-1:0];
            mic_pkg::REG_ROW_ONE:  row_one_ff  <= csr_data[mic_pkg::ROW_W-1:0];
            mic_pkg::REG_ROW_TWO:  row_two_ff  <= csr_data[mic_pkg::ROW_W-1:0];
            default: ;
         endcase
      end
   end

   assign matrix = {row_two_ff, row_one_ff, row_zero_ff};

   mic_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_raw_x    (req_raw_x),
      .req_raw_y    (req_raw_y),
      .req_raw_z    (req_raw_z),
      .bias         (bias_ff),
      .queue_status (queue_status),
      .push         (push),
      .push_data    (push_data)
   );

   mic_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (queue_status)
   );

   mic_back u_back (
      .clock              (clock),
      .reset              (reset),
      .matrix             (matrix),
      .queue_status       (queue_status),
      .pop_data           (pop_data),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_unit_x         (rsp_unit_x),
      .rsp_unit_y         (rsp_unit_y),
      .rsp_unit_z         (rsp_unit_z),
      .rsp_zero_magnitude (rsp_zero_magnitude)
   );

endmodule

>>> sv/mic_front.sv
// mic_front: input stage, takes one sample word and removes the hard-iron bias.
// Depends on mic_pkg.
module mic_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [mic_pkg::RAW_W-1:0] req_raw_x,
   input  logic signed [mic_pkg::RAW_W-1:0] req_raw_y,
   input  logic signed [mic_pkg::RAW_W-1:0] req_raw_z,
   input  logic [mic_pkg::BIAS_W-1:0]   bias,
   input  mic_pkg::queue_status_type    queue_status,
   output logic                         push,
   output mic_pkg::diff_vec_type        push_data
);

   logic                  valid_ff;
   mic_pkg::diff_vec_type diff_ff;
   mic_pkg::diff_vec_type diff_in;
   logic [2:0][mic_pkg::RAW_W-1:0] raw;

   assign raw = {req_raw_z, req_raw_y, req_raw_x};

   // bias subtraction, one extra bit of range
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff_in[i] = {raw[i][mic_pkg::RAW_W-1], raw[i]}
                    - {bias[16*i+15], bias[16*i +: 16]};
      end
   end

   // hold register toward the queue
   assign push      = valid_ff && !queue_status.full;
   assign req_ready = !valid_ff || !queue_status.full;
   assign push_data = diff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         diff_ff <= diff_in;
      end
   end

endmodule

>>> sv/mic_fifo.sv
// mic_fifo: short queue of bias-corrected words between front and back.
// Depends on mic_pkg.
module mic_fifo #(
   parameter int DEPTH = mic_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mic_pkg::diff_vec_type     push_data,
   input  logic                      pop,
   output mic_pkg::diff_vec_type     pop_data,
   output mic_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mic_pkg::diff_vec_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign pop_data     = entry_ff[rd_ptr_ff];

   // pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // front must hold when full, back must not take from an empty queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full || pop) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty) else $error("queue underflow");
   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> !status.empty) else $error("queue lost a word");

endmodule

>>> sv/mic_back.sv
// mic_back: soft-iron multiply, sum of squares, pipelined square root and
// division, axis remap and result register. Depends on mic_pkg.
module mic_back (
   input  logic                          clock,
   input  logic                          reset,
   input  mic_pkg::matrix_type           matrix,
   input  mic_pkg::queue_status_type     queue_status,
   input  mic_pkg::diff_vec_type         pop_data,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [mic_pkg::OUT_W-1:0] rsp_unit_x,
   output logic signed [mic_pkg::OUT_W-1:0] rsp_unit_y,
   output logic signed [mic_pkg::OUT_W-1:0] rsp_unit_z,
   output logic                          rsp_zero_magnitude
);

   localparam int MAG_W  = mic_pkg::MAG_W;
   localparam int ROOT_W = mic_pkg::ROOT_W;
   localparam int QUO_W  = mic_pkg::QUO_W;
   localparam int NUM_W  = mic_pkg::NUM_W;
   localparam int SQ_W   = mic_pkg::SQ_W;
   localparam int HALF_W = mic_pkg::HALF_W;

   typedef logic [2:0][MAG_W-1:0] mag_vec_type;

   typedef struct packed {
      logic                   valid;
      logic                   zero;
      logic [2:0]             neg;
      mag_vec_type            mag;
      logic [SQ_W-1:0]        rem;
      logic [ROOT_W-1:0]      root;
   } root_stage_type;

   typedef struct packed {
      logic                   valid;
      logic                   zero;
      logic [2:0]             neg;
      logic [2:0][NUM_W-1:0]  num;
      logic [2:0][QUO_W-1:0]  quo;
      logic [ROOT_W-1:0]      den;
   } div_stage_type;

   logic advance;

   logic                                 a_valid_ff;
   logic signed [mic_pkg::PROD_W-1:0]    a_prod_ff [3][3];
   logic                                 b_valid_ff;
   logic [2:0]                           b_neg_ff;
   mag_vec_type                          b_mag_ff;
   logic                                 c_valid_ff;
   logic [2:0]                           c_neg_ff;
   mag_vec_type                          c_mag_ff;
   logic [2:0][2*HALF_W-1:0]             c_hh_ff, c_hl_ff, c_ll_ff;
   logic                                 d_valid_ff;
   logic [2:0]                           d_neg_ff;
   mag_vec_type                          d_mag_ff;
   logic [2:0][SQ_W-1:0]                 d_sq_ff;

   root_stage_type root_ff [ROOT_W+1];
   root_stage_type root_in;
   div_stage_type  div_ff  [QUO_W+1];
   div_stage_type  div_in;

   logic                             rsp_valid_ff;
   logic signed [mic_pkg::OUT_W-1:0] unit_x_ff, unit_y_ff, unit_z_ff;
   logic signed [mic_pkg::OUT_W-1:0] unit_x_in, unit_y_in, unit_z_in;
   logic                             zero_ff;

   // whole pipeline moves together unless the result is stuck
   assign advance = !rsp_valid_ff || rsp_ready;
   assign pop     = advance && !queue_status.empty;

   // coefficient products
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= pop;
      end
      if (advance) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               a_prod_ff[r][c] <= $signed(matrix[r][c]) * $signed(pop_data[c]);
            end
         end
      end
   end

   // row sums, sign and magnitude
   always_ff @(posedge clock) begin
      logic signed [mic_pkg::V_W-1:0] v;
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
      if (advance) begin
         for (int r = 0; r < 3; r++) begin
            v = mic_pkg::V_W'(a_prod_ff[r][0]) + mic_pkg::V_W'(a_prod_ff[r][1])
              + mic_pkg::V_W'(a_prod_ff[r][2]);
            b_neg_ff[r] <= v[mic_pkg::V_W-1];
            b_mag_ff[r] <= v[mic_pkg::V_W-1] ? MAG_W'(-v) : MAG_W'(v);
         end
      end
   end

   // split squares into half-width partial products
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         c_valid_ff <= b_valid_ff;
      end
      if (advance) begin
         c_neg_ff <= b_neg_ff;
         c_mag_ff <= b_mag_ff;
         for (int i = 0; i < 3; i++) begin
            c_hh_ff[i] <= b_mag_ff[i][MAG_W-1 -: HALF_W] * b_mag_ff[i][MAG_W-1 -: HALF_W];
            c_hl_ff[i] <= b_mag_ff[i][MAG_W-1 -: HALF_W] * b_mag_ff[i][HALF_W-1:0];
            c_ll_ff[i] <= b_mag_ff[i][HALF_W-1:0] * b_mag_ff[i][HALF_W-1:0];
         end
      end
   end

   // per-axis squares
   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (advance) begin
         d_valid_ff <= c_valid_ff;
      end
      if (advance) begin
         d_neg_ff <= c_neg_ff;
         d_mag_ff <= c_mag_ff;
         for (int i = 0; i < 3; i++) begin
            d_sq_ff[i] <= {c_hh_ff[i], {(2*HALF_W){1'b0}}}
                        + (SQ_W'(c_hl_ff[i]) << (HALF_W + 1))
                        + SQ_W'(c_ll_ff[i]);
         end
      end
   end

   // sum of squares enters the root pipeline
   always_comb begin
      root_in.valid = d_valid_ff;
      root_in.neg   = d_neg_ff;
      root_in.mag   = d_mag_ff;
      root_in.rem   = d_sq_ff[0] + d_sq_ff[1] + d_sq_ff[2];
      root_in.zero  = (root_in.rem == '0);
      root_in.root  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff[0].valid <= 1'b0;
      end else if (advance) begin
         root_ff[0] <= root_in;
      end
   end

   // square root, one result bit per stage, highest first
   for (genvar k = 0; k < ROOT_W; k++) begin : g_root
      localparam int BIT = ROOT_W - 1 - k;
      logic [SQ_W-1:0] trial;
      root_stage_type  nxt;

      always_comb begin
         trial = (SQ_W'(root_ff[k].root) << (BIT + 1)) + (SQ_W'(1) << (2 * BIT));
         nxt   = root_ff[k];
         if (trial <= root_ff[k].rem) begin
            nxt.rem       = root_ff[k].rem - trial;
            nxt.root[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            root_ff[k+1].valid <= 1'b0;
         end else if (advance) begin
            root_ff[k+1] <= nxt;
         end
      end
   end

   // dividend is magnitude in Q1.14 plus half the root for rounding
   always_comb begin
      div_in.valid = root_ff[ROOT_W].valid;
      div_in.zero  = root_ff[ROOT_W].zero;
      div_in.neg   = root_ff[ROOT_W].neg;
      div_in.den   = root_ff[ROOT_W].root;
      div_in.quo   = '0;
      for (int i = 0; i < 3; i++) begin
         div_in.num[i] = (NUM_W'(root_ff[ROOT_W].mag[i]) << mic_pkg::FRAC_W)
                       + NUM_W'(root_ff[ROOT_W].root >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff[0].valid <= 1'b0;
      end else if (advance) begin
         div_ff[0] <= div_in;
      end
   end

   // restoring division, three lanes, one quotient bit per stage
   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      localparam int BIT = QUO_W - 1 - k;
      logic [NUM_W-1:0] shifted;
      div_stage_type    nxt;

      always_comb begin
         shifted = NUM_W'(div_ff[k].den) << BIT;
         nxt     = div_ff[k];
         for (int j = 0; j < 3; j++) begin
            if (div_ff[k].num[j] >= shifted) begin
               nxt.num[j]      = div_ff[k].num[j] - shifted;
               nxt.quo[j][BIT] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[k+1].valid <= 1'b0;
         end else if (advance) begin
            div_ff[k+1] <= nxt;
         end
      end
   end

   // signs and axis remap: body x = y, body y = -x, body z = z
   always_comb begin
      logic signed [mic_pkg::OUT_W-1:0] q0, q1, q2;
      q0 = mic_pkg::OUT_W'(div_ff[QUO_W].quo[0]);
      q1 = mic_pkg::OUT_W'(div_ff[QUO_W].quo[1]);
      q2 = mic_pkg::OUT_W'(div_ff[QUO_W].quo[2]);
      if (div_ff[QUO_W].zero) begin
         unit_x_in = '0;
         unit_y_in = '0;
         unit_z_in = '0;
      end else begin
         unit_x_in = div_ff[QUO_W].neg[1] ? -q1 : q1;
         unit_y_in = div_ff[QUO_W].neg[0] ? q0 : -q0;
         unit_z_in = div_ff[QUO_W].neg[2] ? -q2 : q2;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_ff[QUO_W].valid;
      end
      if (advance) begin
         unit_x_ff <= unit_x_in;
         unit_y_ff <= unit_y_in;
         unit_z_ff <= unit_z_in;
         zero_ff   <= div_ff[QUO_W].zero;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_unit_x         = unit_x_ff;
   assign rsp_unit_y         = unit_y_ff;
   assign rsp_unit_z         = unit_z_ff;
   assign rsp_zero_magnitude = zero_ff;

   // zero flag forces a null vector; a nonzero word never leaves an empty one
   a_zero_null: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && zero_ff |-> unit_x_ff == 0 && unit_y_ff == 0 && unit_z_ff == 0)
      else $error("zero flag with nonzero vector");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(unit_x_ff) && $stable(zero_ff))
      else $error("result changed while stalled");
   a_pop_when_moving: assert property (@(posedge clock) disable iff (reset)
      pop |-> advance) else $error("pop while stalled");

endmodule

>>> test/mic_checker.sv
// mic_checker: watches the sample and unit-vector channels, predicts each
// calibrated unit vector and compares it. Depends on mic_pkg.
module mic_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic signed [mic_pkg::RAW_W-1:0] req_raw_x,
   input  logic signed [mic_pkg::RAW_W-1:0] req_raw_y,
   input  logic signed [mic_pkg::RAW_W-1:0] req_raw_z,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic signed [mic_pkg::OUT_W-1:0] rsp_unit_x,
   input  logic signed [mic_pkg::OUT_W-1:0] rsp_unit_y,
   input  logic signed [mic_pkg::OUT_W-1:0] rsp_unit_z,
   input  logic                             rsp_zero_magnitude,
   input  logic                             csr_write,
   input  logic [1:0]                       csr_index,
   input  logic [mic_pkg::CSR_W-1:0]        csr_data,
   output int                               fail_count,
   output int                               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [mic_pkg::OUT_W-1:0] ux;
      logic signed [mic_pkg::OUT_W-1:0] uy;
      logic signed [mic_pkg::OUT_W-1:0] uz;
      logic                             zm;
   } unit_word_type;

   logic [mic_pkg::BIAS_W-1:0] bias_reg;
   logic [mic_pkg::ROW_W-1:0]  row_reg [3];
   unit_word_type              expected_units [$];

   // rounded q1.14 component, half away from zero
   function automatic longint scale_component(longint v, longint unsigned r);
      longint unsigned m, q;
      m = (v < 0) ? -v : v;
      q = (m * 64'd16384 + (r >> 1)) / r;
      if (q > 16384) q = 16384;
      return (v < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic unit_word_type calibrate(logic signed [mic_pkg::RAW_W-1:0] rx,
                                               logic signed [mic_pkg::RAW_W-1:0] ry,
                                               logic signed [mic_pkg::RAW_W-1:0] rz);
      longint d [3];
      longint v [3];
      logic signed [mic_pkg::COEF_W-1:0] coef;
      logic [127:0] sum_sq, cand_sq;
      longint unsigned root, cand, mag;
      unit_word_type w;
      d[0] = longint'(rx) - longint'($signed(bias_reg[15:0]));
      d[1] = longint'(ry) - longint'($signed(bias_reg[31:16]));
      d[2] = longint'(rz) - longint'($signed(bias_reg[47:32]));
      sum_sq = 0;
      for (int i = 0; i < 3; i++) begin
         v[i] = 0;
         for (int c = 0; c < 3; c++) begin
            coef = row_reg[i][18*c +: 18];
            v[i] += longint'(coef) * d[c];
         end
         mag = (v[i] < 0) ? -v[i] : v[i];
         sum_sq += 128'(mag) * 128'(mag);
      end
      w = '0;
      if (sum_sq == 0) begin
         w.zm = 1'b1;
         return w;
      end
      // bitwise integer square root
      root = 0;
      for (int b = 36; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         cand_sq = 128'(cand) * 128'(cand);
         if (cand_sq <= sum_sq) root = cand;
      end
      // sensor to body axes
      w.ux = mic_pkg::OUT_W'(scale_component(v[1], root));
      w.uy = mic_pkg::OUT_W'(-scale_component(v[0], root));
      w.uz = mic_pkg::OUT_W'(scale_component(v[2], root));
      return w;
   endfunction

   assign pending_count = expected_units.size();

   always @(posedge clock) begin
      unit_word_type got, want;
      if (reset) begin
         bias_reg   <= '0;
         row_reg[0] <= mic_pkg::ROW_ZERO_RESET;
         row_reg[1] <= mic_pkg::ROW_ONE_RESET;
         row_reg[2] <= mic_pkg::ROW_TWO_RESET;
         expected_units.delete();
         fail_count <= 0;
      end else begin
         // register shadow
         if (csr_write) begin
            case (mic_pkg::reg_index_type'(csr_index))
               mic_pkg::REG_BIAS:     bias_reg   <= csr_data[mic_pkg::BIAS_W-1:0];
               mic_pkg::REG_ROW_ZERO: row_reg[0] <= csr_data;
               mic_pkg::REG_ROW_ONE:  row_reg[1] <= csr_data;
               mic_pkg::REG_ROW_TWO:  row_reg[2] <= csr_data;
               default: ;
            endcase
         end
         // accepted sample word
         if (req_valid && req_ready)
            expected_units.push_back(calibrate(req_raw_x, req_raw_y, req_raw_z));
         // accepted result word
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_unit_x, rsp_unit_y, rsp_unit_z, rsp_zero_magnitude};
            if (expected_units.size() == 0) begin
               $error("unexpected result word");
               fail_count <= fail_count + 1;
            end else begin
               want = expected_units.pop_front();
               if (got !== want) begin
                  if (got.ux !== want.ux)
                     $error("unit_x expected %0d actual %0d", want.ux, got.ux);
                  if (got.uy !== want.uy)
                     $error("unit_y expected %0d actual %0d", want.uy, got.uy);
                  if (got.uz !== want.uz)
                     $error("unit_z expected %0d actual %0d", want.uz, got.uz);
                  if (got.zm !== want.zm)
                     $error("zero_magnitude expected %0d actual %0d", want.zm, got.zm);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

>>> test/tb_top.sv
// tb_top: stimulus and verdict for the magnetometer calibration block.
// Depends on mic_pkg, magnetometer_iron_calibration and mic_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WORDS = 1700;
   localparam int DRAIN_CYCLES = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [mic_pkg::RAW_W-1:0] req_raw_x = '0, req_raw_y = '0, req_raw_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [mic_pkg::OUT_W-1:0] rsp_unit_x, rsp_unit_y, rsp_unit_z;
   logic rsp_zero_magnitude;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = '0;
   logic [mic_pkg::CSR_W-1:0] csr_data = '0;
   int fail_count, pending_count;
   bit hold_off = 1'b0;

   always #4 clock = ~clock;

   magnetometer_iron_calibration u_top (.*);
   mic_checker u_checker (.*);

   // receiver: random stall per word, plus one long hold-off
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            @(negedge clock);
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if ($urandom_range(0, 5) == 0) gap = 0;
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            rsp_ready <= 1'b1;
            @(posedge clock);
            while (!rsp_valid && !hold_off) @(posedge clock);
            @(negedge clock);
         end
      end
   end

   // sample word, waits for acceptance
   task automatic send_sample(logic [mic_pkg::RAW_W-1:0] x, logic [mic_pkg::RAW_W-1:0] y,
                              logic [mic_pkg::RAW_W-1:0] z, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_raw_x <= x;
      req_raw_y <= y;
      req_raw_z <= z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_sender();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   // config write, only once the block is drained
   task automatic write_reg(mic_pkg::reg_index_type idx, logic [mic_pkg::CSR_W-1:0] value);
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic [17:0] coef(int v);
      return 18'(v);
   endfunction

   function automatic logic [mic_pkg::ROW_W-1:0] rand_row(bit wide);
      logic [mic_pkg::ROW_W-1:0] r;
      for (int c = 0; c < 3; c++)
         r[18*c +: 18] = wide ? 18'($urandom) : coef($urandom_range(0, 8192) - 4096);
      return r;
   endfunction

   function automatic logic [mic_pkg::RAW_W-1:0] rand_raw(int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 64) - 32);
         2: return ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
         default: return 16'($urandom_range(0, 4000) - 2000);
      endcase
   endfunction

   task automatic random_phase(int words);
      int m;
      for (int n = 0; n < words; n++) begin
         m = $urandom_range(0, 5);
         send_sample(rand_raw(m), rand_raw(m), rand_raw(m),
                     ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17));
      end
      idle_sender();
   endtask

   // main stimulus
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset matrix, extremes and zero vector
      send_sample(16'h0000, 16'h0000, 16'h0000, 0);
      send_sample(16'h7fff, 16'h7fff, 16'h7fff, 0);
      send_sample(16'h8000, 16'h8000, 16'h8000, 0);
      send_sample(16'h7fff, 16'h8000, 16'h0000, 1);
      send_sample(16'h0001, 16'h0000, 16'h0000, 0);
      send_sample(16'h0000, 16'hffff, 16'h0000, 0);
      send_sample(16'h0000, 16'h0000, 16'h0001, 2);
      send_sample(16'h0003, 16'h0004, 16'h0000, 0);
      send_sample(16'hffff, 16'hffff, 16'hffff, 0);
      idle_sender();

      // bias at extremes, input equal to bias gives zero magnitude
      write_reg(mic_pkg::REG_BIAS, {16'h8000, 16'h7fff, 16'h1234});
      send_sample(16'h1234, 16'h7fff, 16'h8000, 0);
      send_sample(16'h7fff, 16'h8000, 16'h7fff, 0);
      send_sample(16'h8000, 16'h7fff, 16'h8000, 0);
      idle_sender();

      // extreme matrix coefficients
      write_reg(mic_pkg::REG_ROW_ZERO, {3{18'h1ffff}});
      write_reg(mic_pkg::REG_ROW_ONE, {3{18'h20000}});
      write_reg(mic_pkg::REG_ROW_TWO, {18'h20000, 18'h1ffff, 18'h3ffff});
      send_sample(16'h8000, 16'h7fff, 16'h7fff, 0);
      send_sample(16'h7fff, 16'h8000, 16'h8000, 0);
      send_sample(16'h0000, 16'h0000, 16'h0000, 0);
      idle_sender();

      // singular matrix: all zero rows
      write_reg(mic_pkg::REG_ROW_ZERO, '0);
      write_reg(mic_pkg::REG_ROW_ONE, '0);
      write_reg(mic_pkg::REG_ROW_TWO, '0);
      send_sample(16'h7fff, 16'h1111, 16'h8000, 0);
      idle_sender();

      // all-ones data, then wide random rows
      write_reg(mic_pkg::REG_BIAS, '1);
      write_reg(mic_pkg::REG_ROW_ZERO, '1);
      write_reg(mic_pkg::REG_ROW_ONE, rand_row(1));
      write_reg(mic_pkg::REG_ROW_TWO, rand_row(1));
      random_phase(RANDOM_WORDS / 6);

      // long receiver hold-off while the sender keeps offering
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(negedge clock);
            hold_off = 1'b0;
         end
         random_phase(40);
      join

      // several random settings, mostly near-identity matrices
      for (int p = 0; p < 5; p++) begin
         write_reg(mic_pkg::REG_BIAS, {16'($urandom), 16'($urandom), 16'($urandom)});
         write_reg(mic_pkg::REG_ROW_ZERO,
                   (p == 4) ? rand_row(1) : rand_row(0) + mic_pkg::ROW_ZERO_RESET);
         write_reg(mic_pkg::REG_ROW_ONE,
                   (p == 4) ? rand_row(1) : rand_row(0) + mic_pkg::ROW_ONE_RESET);
         write_reg(mic_pkg::REG_ROW_TWO,
                   (p == 4) ? rand_row(1) : rand_row(0) + mic_pkg::ROW_TWO_RESET);
         random_phase(RANDOM_WORDS / 6);
      end

      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // run-time limit
   initial begin
      #8ms;
      $display("status: fail");
      $finish;
   end
endmodule
